// ----- src/ppt_pkg.sv -----
// Shared types and constants of the peer presence table.
package ppt_pkg;

  localparam int unsigned AddrWidth = 32;
  localparam int unsigned AgeWidth = 8;
  localparam int unsigned IndexWidth = 4;
  localparam logic [AgeWidth-1:0] AgeMax = 8'd255;
  localparam logic [AgeWidth-1:0] TimeoutReset = 8'd5;
  localparam logic [4:0] MaxOfflineReports = 5'd16;

  typedef enum logic [2:0] {
    EV_OWN     = 3'd0,
    EV_REFRESH = 3'd1,
    EV_BACK    = 3'd2,
    EV_ADDED   = 3'd3,
    EV_FULL    = 3'd4,
    EV_OFFLINE = 3'd5,
    EV_DONE    = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_OWN_A     = 2'd1,
    CFG_OWN_B     = 2'd2,
    CFG_OWN_EN    = 2'd3
  } cfg_reg_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture the input beat
    logic scan_start;  // rewind the slot walk
    logic hb_adv;      // step the walk, read only
    logic tick_adv;    // step the walk, age and write back
    logic hb_hit;      // refresh the matched slot and report it
    logic hb_miss;     // append the sender or report a full table
    logic emit_own;    // report an own address
    logic emit_done;   // report the end of a tick
  } ppt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_tick;
    logic own_hit;
    logic hit;
    logic scan_busy;
    logic off_pending;
    logic out_free;
  } ppt_status_t;

endpackage

// ----- src/ppt_ctrl.sv -----
// Sequencer of the peer presence table: accepts beats and steps the slot walk.
module ppt_ctrl
  import ppt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ppt_status_t status_i,
  output ppt_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_CHECK   = 5'b00010,
    ST_HB_SCAN = 5'b00100,
    ST_TK_SCAN = 5'b01000,
    ST_TK_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.is_tick) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_TK_SCAN;
        end else if (status_i.own_hit) begin
          if (status_i.out_free) begin
            cmd_o.emit_own = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_HB_SCAN;
        end
      end
      ST_HB_SCAN: begin
        if (status_i.hit) begin
          if (status_i.out_free) begin
            cmd_o.hb_hit = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (status_i.scan_busy) begin
          cmd_o.hb_adv = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.hb_miss = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_TK_SCAN: begin
        // hold while an offline report waits for the output register
        if (status_i.off_pending && !status_i.out_free) begin
          state_d = ST_TK_SCAN;
        end else if (status_i.scan_busy) begin
          cmd_o.tick_adv = 1'b1;
        end else begin
          state_d = ST_TK_DONE;
        end
      end
      ST_TK_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/ppt_datapath.sv -----
// Datapath of the peer presence table: slot memories, walk counters, output register.
module ppt_datapath
  import ppt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ppt_cmd_t              cmd_i,
  output ppt_status_t           status_o,
  input  logic                  command_i,
  input  logic [AddrWidth-1:0]  sender_ip_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [AddrWidth-1:0]  cfg_data_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [2:0]            event_res_o,
  output logic [IndexWidth-1:0] entry_index_o,
  output logic [AddrWidth-1:0]  entry_ip_o,
  output logic                  last_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned StW  = AgeWidth + 1;

  // configuration
  logic [AgeWidth-1:0]  timeout_q;
  logic [AddrWidth-1:0] own_a_q, own_b_q;
  logic [1:0]           own_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      own_a_q   <= '0;
      own_b_q   <= '0;
      own_en_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i[AgeWidth-1:0];
        CFG_OWN_A:   own_a_q   <= cfg_data_i;
        CFG_OWN_B:   own_b_q   <= cfg_data_i;
        CFG_OWN_EN:  own_en_q  <= cfg_data_i[1:0];
        default:     timeout_q <= timeout_q;
      endcase
    end
  end

  // captured beat
  logic                 tick_q;
  logic [AddrWidth-1:0] ip_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tick_q <= command_i;
      ip_q   <= sender_ip_i;
    end
  end

  // walk control
  logic [CntW-1:0] used_q, rd_idx_q;
  logic [IdxW-1:0] ev_idx_q;
  logic            pv_q;
  logic [4:0]      rep_q;
  logic            rd_more, full, adv, rd_en;

  assign rd_more = (rd_idx_q < used_q);
  assign full    = (used_q == CntW'(TABLE_DEPTH));
  assign adv     = cmd_i.hb_adv | cmd_i.tick_adv;
  assign rd_en   = adv & rd_more;

  // slot memories: address, and {online, age}
  logic [AddrWidth-1:0] addr_mem [TABLE_DEPTH];
  logic [StW-1:0]       state_mem [TABLE_DEPTH];
  logic [AddrWidth-1:0] rd_addr_q;
  logic [StW-1:0]       rd_state_q;

  // evaluation of the slot under the walk
  logic                rd_online, aged_out, off_pending;
  logic [AgeWidth-1:0] new_age;

  assign rd_online   = rd_state_q[StW-1];
  assign new_age     = (rd_state_q[AgeWidth-1:0] == AgeMax) ? AgeMax
                                                            : rd_state_q[AgeWidth-1:0] + 8'd1;
  assign aged_out    = (new_age > timeout_q);
  assign off_pending = pv_q & rd_online & aged_out & (rep_q != MaxOfflineReports);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      rd_idx_q <= '0;
      pv_q     <= 1'b0;
      rep_q    <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        rd_idx_q <= '0;
        pv_q     <= 1'b0;
        rep_q    <= '0;
      end else if (adv) begin
        pv_q <= rd_more;
        if (rd_more) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
        if (cmd_i.tick_adv && off_pending) begin
          rep_q <= rep_q + 5'd1;
        end
      end
      if (cmd_i.hb_miss && !full) begin
        used_q <= used_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ev_idx_q   <= rd_idx_q[IdxW-1:0];
      rd_addr_q  <= addr_mem[rd_idx_q[IdxW-1:0]];
      rd_state_q <= state_mem[rd_idx_q[IdxW-1:0]];
    end
  end

  logic            st_we;
  logic [IdxW-1:0] st_wa;
  logic [StW-1:0]  st_wd;
  logic            add_we;

  assign add_we = cmd_i.hb_miss & ~full;

  always_comb begin
    st_we = 1'b0;
    st_wa = ev_idx_q;
    st_wd = {1'b1, {AgeWidth{1'b0}}};
    if (cmd_i.hb_hit) begin
      st_we = 1'b1;
    end else if (add_we) begin
      st_we = 1'b1;
      st_wa = used_q[IdxW-1:0];
    end else if (cmd_i.tick_adv && pv_q) begin
      st_we = 1'b1;
      st_wd = {rd_online & ~aged_out, new_age};
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      state_mem[st_wa] <= st_wd;
    end
    if (add_we) begin
      addr_mem[used_q[IdxW-1:0]] <= ip_q;
    end
  end

  // output register
  logic                  out_valid_q;
  event_e                out_ev_q, ev_d;
  logic [IndexWidth-1:0] out_idx_q, idx_d;
  logic [AddrWidth-1:0]  out_ip_q, ip_d;
  logic                  out_last_q, last_d;
  logic                  emit, out_free;

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    emit   = 1'b1;
    ev_d   = EV_DONE;
    idx_d  = '0;
    ip_d   = ip_q;
    last_d = 1'b1;
    if (cmd_i.emit_own) begin
      ev_d = EV_OWN;
    end else if (cmd_i.hb_hit) begin
      ev_d  = rd_online ? EV_REFRESH : EV_BACK;
      idx_d = IndexWidth'(ev_idx_q);
    end else if (cmd_i.hb_miss) begin
      if (full) begin
        ev_d = EV_FULL;
      end else begin
        ev_d  = EV_ADDED;
        idx_d = IndexWidth'(used_q[IdxW-1:0]);
      end
    end else if (cmd_i.tick_adv && off_pending) begin
      ev_d   = EV_OFFLINE;
      idx_d  = IndexWidth'(ev_idx_q);
      ip_d   = rd_addr_q;
      last_d = 1'b0;
    end else if (cmd_i.emit_done) begin
      ip_d = '0;
    end else begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ev_q   <= ev_d;
      out_idx_q  <= idx_d;
      out_ip_q   <= ip_d;
      out_last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = out_ev_q;
  assign entry_index_o = out_idx_q;
  assign entry_ip_o    = out_ip_q;
  assign last_o        = out_last_q;

  assign status_o.is_tick     = tick_q;
  assign status_o.own_hit     = (own_en_q[0] && (ip_q == own_a_q)) ||
                                (own_en_q[1] && (ip_q == own_b_q));
  assign status_o.hit         = pv_q & (rd_addr_q == ip_q);
  assign status_o.scan_busy   = pv_q | rd_more;
  assign status_o.off_pending = off_pending;
  assign status_o.out_free    = out_free;

endmodule

// ----- src/peer_presence_table_with_aging_top.sv -----
// Top level of the peer presence table with aging.
//
// Holds up to TABLE_DEPTH peer IPv4 addresses, each with an online flag and an
// age in ticks. A heartbeat beat (command 0) is first checked against the two
// enabled own addresses, then looked up by walking the filled slots one per
// clock; a hit clears the age and marks the peer online, a miss appends the
// sender in the next free slot or reports a full table. A tick beat (command 1)
// walks every filled slot once, ages it (saturating at 255) and reports each
// online peer whose age now exceeds timeout_ticks as gone offline, at most 16
// reports per tick, and closes with a done beat carrying last = 1. A heartbeat
// gives one result beat, a tick gives the offline beats and then the done beat.
// Slots fill in order and are never freed, so a fill count stands in for valid
// bits and no clearing pass runs after reset. Rate: one item at a time; the
// slot memory has a single registered read port, so a walk reads the filled
// slots in turn, and the next beat is taken only once the block is back in
// idle, when the last beat has been handled and its results registered, which
// waits while the output side holds stall high on a pending result.
// Configuration writes are always taken (cfg_ready_o is tied high) and are
// meant to happen only while the block is idle.
module peer_presence_table_with_aging_top
  import ppt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input beats
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [AddrWidth-1:0]  sender_ip_i,
  // result beats
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            event_res_o,
  output logic [IndexWidth-1:0] entry_index_o,
  output logic [AddrWidth-1:0]  entry_ip_o,
  output logic                  last_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [AddrWidth-1:0]  cfg_data_i
);

  ppt_cmd_t    cmd;
  ppt_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequence the walk
  ppt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // hold the table, the registers and the result beat
  ppt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .command_i     (command_i),
    .sender_ip_i   (sender_ip_i),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .event_res_o   (event_res_o),
    .entry_index_o (entry_index_o),
    .entry_ip_o    (entry_ip_o),
    .last_o        (last_o)
  );

endmodule
